FILE: hdl/lkvc_pkg.sv
`timescale 1ns / 1ps

package lkvc_pkg;

   // field widths of the request and response
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int LIMIT_BITS  = 5;
   localparam int OCC_BITS    = 5;
   localparam int COUNT_BITS  = 32;

   // capacity register value after reset
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(10);

   // request operation codes
   typedef enum logic [1:0] {
      OP_GET      = 2'd0,
      OP_PUT      = 2'd1,
      OP_REMOVE   = 2'd2,
      OP_CONTAINS = 2'd3
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [KEY_BITS-1:0]   lookup_key;
      logic [VALUE_BITS-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [VALUE_BITS-1:0] read_value;
      logic [OCC_BITS-1:0]   occupancy;
      logic [COUNT_BITS-1:0] hit_total;
      logic [COUNT_BITS-1:0] miss_total;
   } rsp_type;

endpackage

FILE: hdl/lkvc_match.sv
`timescale 1ns / 1ps

module lkvc_match #(
   parameter int ENTRIES = 16
) (
   input  logic [ENTRIES-1:0]                  entry_valid,
   input  logic [lkvc_pkg::KEY_BITS-1:0]       entry_key [ENTRIES],
   input  logic [lkvc_pkg::VALUE_BITS-1:0]     entry_value [ENTRIES],
   input  logic [lkvc_pkg::KEY_BITS-1:0]       lookup_key,
   output logic [ENTRIES-1:0]                  hit_vec,
   output logic [lkvc_pkg::VALUE_BITS-1:0]     hit_value
);

   // parallel key compare against every valid entry
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = entry_valid[i] && (entry_key[i] == lookup_key);
      end
   end

   // and-or select of the matching entry's value (at most one match)
   always_comb begin
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit_vec[i]) begin
            hit_value = hit_value | entry_value[i];
         end
      end
   end

endmodule

FILE: hdl/lru_key_value_cache_top.sv
`timescale 1ns / 1ps

// channel   ports                         direction  moves
// request   req_valid/req_ready/req_data  in         op, lookup_key, write_value
// response  rsp_valid/rsp_ready/rsp_data  out        found, read_value, occupancy, totals
// csr       csr_write_enable/_data        in         capacity_limit, no wait
//
// One request per cycle while the response is not stalled: a request is taken
// into the input register, the whole lookup and table update are computed
// combinationally from it, and the response register and table state load
// together when it moves on. A stalled response holds itself and any waiting
// request; an empty input register can still take one more request during the stall.
// Synchronous reset empties the table, zeroes counters and sets capacity to 10.

module lru_key_value_cache_top #(
   parameter int ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lkvc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lkvc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_enable,
   input  logic [lkvc_pkg::LIMIT_BITS-1:0]     csr_write_data
);

   localparam int RANK_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   // pipeline control
   logic                                 req_valid_ff;
   lkvc_pkg::req_type                    req_ff;
   logic                                 rsp_valid_ff;
   lkvc_pkg::rsp_type                    rsp_ff;
   lkvc_pkg::rsp_type                    rsp_in;
   logic                                 advance;
   logic                                 fire;

   // table state
   logic [lkvc_pkg::LIMIT_BITS-1:0]      limit_ff;
   logic [ENTRIES-1:0]                   valid_ff, valid_in;
   logic [RANK_W-1:0]                    rank_ff [ENTRIES];
   logic [RANK_W-1:0]                    rank_in [ENTRIES];
   logic [lkvc_pkg::KEY_BITS-1:0]        key_ff [ENTRIES];
   logic [lkvc_pkg::KEY_BITS-1:0]        key_in [ENTRIES];
   logic [lkvc_pkg::VALUE_BITS-1:0]      value_ff [ENTRIES];
   logic [lkvc_pkg::VALUE_BITS-1:0]      value_in [ENTRIES];
   logic [CNT_W-1:0]                     count_ff, count_in;
   logic [lkvc_pkg::COUNT_BITS-1:0]      hit_ff, hit_in;
   logic [lkvc_pkg::COUNT_BITS-1:0]      miss_ff, miss_in;

   // lookup results
   logic [ENTRIES-1:0]                   hit_vec;
   logic [lkvc_pkg::VALUE_BITS-1:0]      hit_value;
   logic                                 hit;
   logic [RANK_W-1:0]                    hit_rank;
   logic [RANK_W-1:0]                    oldest_rank;
   logic [ENTRIES-1:0]                   oldest_vec;
   logic [31:0]                          cap_eff;
   logic                                 evict;
   logic [ENTRIES-1:0]                   kept_vec;
   logic [ENTRIES-1:0]                   free_vec;
   logic [lkvc_pkg::VALUE_BITS-1:0]      read_value;

   // handshake: both stages move together, the input stage refills freely
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid_ff && advance;
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   lkvc_match #(
      .ENTRIES(ENTRIES)
   ) u_match (
      .entry_valid (valid_ff),
      .entry_key   (key_ff),
      .entry_value (value_ff),
      .lookup_key  (req_ff.lookup_key),
      .hit_vec     (hit_vec),
      .hit_value   (hit_value)
   );

   assign hit = |hit_vec;

   // rank of the matching entry
   always_comb begin
      hit_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit_vec[i]) begin
            hit_rank = hit_rank | rank_ff[i];
         end
      end
   end

   // least recent entry holds the rank count - 1
   assign oldest_rank = RANK_W'(count_ff - CNT_W'(1));

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         oldest_vec[i] = valid_ff[i] && (rank_ff[i] == oldest_rank);
      end
   end

   // effective capacity: zero acts as one, clamped to the table size
   always_comb begin
      priority if (limit_ff == '0) begin
         cap_eff = 32'd1;
      end else if (32'(limit_ff) > 32'(ENTRIES)) begin
         cap_eff = 32'(ENTRIES);
      end else begin
         cap_eff = 32'(limit_ff);
      end
   end

   assign evict    = 32'(count_ff) >= cap_eff;
   assign kept_vec = evict ? (valid_ff & ~oldest_vec) : valid_ff;
   // lowest free slot after any eviction
   assign free_vec = ~kept_vec & (kept_vec + ENTRIES'(1));

   // next table state for the request in the input register
   always_comb begin
      valid_in   = valid_ff;
      rank_in    = rank_ff;
      key_in     = key_ff;
      value_in   = value_ff;
      count_in   = count_ff;
      hit_in     = hit_ff;
      miss_in    = miss_ff;
      read_value = '0;
      unique case (req_ff.op)
         lkvc_pkg::OP_GET: begin
            if (hit) begin
               read_value = hit_value;
               hit_in     = hit_ff + lkvc_pkg::COUNT_BITS'(1);
               // promote: younger entries age by one
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit_vec[i]) begin
                     rank_in[i] = '0;
                  end else if (valid_ff[i] && rank_ff[i] < hit_rank) begin
                     rank_in[i] = rank_ff[i] + RANK_W'(1);
                  end
               end
            end else begin
               miss_in = miss_ff + lkvc_pkg::COUNT_BITS'(1);
            end
         end
         lkvc_pkg::OP_PUT: begin
            if (hit) begin
               // overwrite and promote
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit_vec[i]) begin
                     rank_in[i]  = '0;
                     value_in[i] = req_ff.write_value;
                  end else if (valid_ff[i] && rank_ff[i] < hit_rank) begin
                     rank_in[i] = rank_ff[i] + RANK_W'(1);
                  end
               end
            end else begin
               // insert, evicting the least recent entry when full
               for (int i = 0; i < ENTRIES; i++) begin
                  if (free_vec[i]) begin
                     valid_in[i] = 1'b1;
                     rank_in[i]  = '0;
                     key_in[i]   = req_ff.lookup_key;
                     value_in[i] = req_ff.write_value;
                  end else if (kept_vec[i]) begin
                     rank_in[i] = rank_ff[i] + RANK_W'(1);
                  end else begin
                     valid_in[i] = 1'b0;
                  end
               end
               if (!evict) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         lkvc_pkg::OP_REMOVE: begin
            if (hit) begin
               // drop: older entries move up by one
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit_vec[i]) begin
                     valid_in[i] = 1'b0;
                     rank_in[i]  = '0;
                  end else if (valid_ff[i] && rank_ff[i] > hit_rank) begin
                     rank_in[i] = rank_ff[i] - RANK_W'(1);
                  end
               end
               count_in = count_ff - CNT_W'(1);
            end
         end
         lkvc_pkg::OP_CONTAINS: begin
            read_value = '0;
         end
         default: begin
            read_value = '0;
         end
      endcase
   end

   // response fields
   always_comb begin
      rsp_in.found      = hit;
      rsp_in.read_value = read_value;
      rsp_in.occupancy  = lkvc_pkg::OCC_BITS'(count_in);
      rsp_in.hit_total  = hit_in;
      rsp_in.miss_total = miss_in;
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= lkvc_pkg::LIMIT_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            valid_ff     <= valid_in;
            count_ff     <= count_in;
            hit_ff       <= hit_in;
            miss_ff      <= miss_in;
            rank_ff      <= rank_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff   <= rsp_in;
         key_ff   <= key_in;
         value_ff <= value_in;
      end
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int CACHE_ENTRIES = 16;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int MAX_WAIT      = 18;
   localparam int PRINT_LIMIT   = 50;

   // block ports
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   lkvc_pkg::req_type               req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   lkvc_pkg::rsp_type               rsp_data;
   logic                            csr_write_enable = 1'b0;
   logic [lkvc_pkg::LIMIT_BITS-1:0] csr_write_data = '0;

   // shadow copy of the cache contents
   logic [lkvc_pkg::LIMIT_BITS-1:0] capacity_setting = lkvc_pkg::LIMIT_RESET;
   bit                              slot_used  [CACHE_ENTRIES];
   logic [lkvc_pkg::KEY_BITS-1:0]   slot_key   [CACHE_ENTRIES];
   logic [lkvc_pkg::VALUE_BITS-1:0] slot_value [CACHE_ENTRIES];
   int                              slot_age   [CACHE_ENTRIES];
   int                              occupied = 0;
   logic [lkvc_pkg::COUNT_BITS-1:0] hit_count = '0;
   logic [lkvc_pkg::COUNT_BITS-1:0] miss_count = '0;

   // request stream and predicted responses
   lkvc_pkg::req_type pending_requests [$];
   lkvc_pkg::rsp_type predicted_responses [$];

   int  mismatch_count = 0;
   int  response_index = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  accept_hold = 0;
   bit  sender_calm = 1'b0;
   bit  receiver_calm = 1'b0;
   lkvc_pkg::rsp_type wanted;

   int capacity_plan [11] = '{16, 2, 31, 0, 7, 1, 12, 16, 3, 10, 5};

   lru_key_value_cache_top #(
      .ENTRIES(CACHE_ENTRIES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   // clock generation
   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // idle length for one request, with occasional stretches of none
   function automatic int next_wait(inout bit calm);
      if ($urandom_range(0, 39) == 0)
         calm = !calm;
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // make an entry the most recent, younger ones age by one
   function automatic void promote_entry(int slot);
      int i;
      int rank;
      rank = slot_age[slot];
      for (i = 0; i < CACHE_ENTRIES; i++)
         if (slot_used[i] && slot_age[i] < rank)
            slot_age[i]++;
      slot_age[slot] = 0;
   endfunction

   // invalidate an entry, older ones move up by one
   function automatic void retire_entry(int slot);
      int i;
      int rank;
      rank = slot_age[slot];
      slot_used[slot] = 1'b0;
      slot_age[slot] = 0;
      for (i = 0; i < CACHE_ENTRIES; i++)
         if (slot_used[i] && slot_age[i] > rank)
            slot_age[i]--;
      if (occupied > 0)
         occupied--;
   endfunction

   // apply one request to the shadow cache and return its response
   function automatic lkvc_pkg::rsp_type apply_request(lkvc_pkg::req_type item);
      lkvc_pkg::rsp_type result;
      int      i;
      int      hit_slot;
      int      oldest;
      int      free_slot;
      int      usable;
      result = '0;
      hit_slot = -1;
      for (i = 0; i < CACHE_ENTRIES; i++)
         if (hit_slot < 0 && slot_used[i] && slot_key[i] == item.lookup_key)
            hit_slot = i;

      case (item.op)
         lkvc_pkg::OP_GET: begin
            if (hit_slot >= 0) begin
               result.read_value = slot_value[hit_slot];
               promote_entry(hit_slot);
               hit_count++;
            end else begin
               miss_count++;
            end
         end
         lkvc_pkg::OP_PUT: begin
            if (hit_slot >= 0) begin
               slot_value[hit_slot] = item.write_value;
               promote_entry(hit_slot);
            end else begin
               // out-of-range capacity is clamped to 1..entries
               usable = (capacity_setting == 0) ? 1 :
                        (capacity_setting > CACHE_ENTRIES) ? CACHE_ENTRIES :
                        int'(capacity_setting);
               // one eviction at most, even if the limit was lowered
               if (occupied >= usable) begin
                  oldest = -1;
                  for (i = 0; i < CACHE_ENTRIES; i++)
                     if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
                        oldest = i;
                  if (oldest >= 0)
                     retire_entry(oldest);
               end
               free_slot = -1;
               for (i = 0; i < CACHE_ENTRIES; i++) begin
                  if (!slot_used[i]) begin
                     if (free_slot < 0)
                        free_slot = i;
                  end else begin
                     slot_age[i]++;
                  end
               end
               if (free_slot >= 0) begin
                  slot_used[free_slot]  = 1'b1;
                  slot_key[free_slot]   = item.lookup_key;
                  slot_value[free_slot] = item.write_value;
                  slot_age[free_slot]   = 0;
                  occupied++;
               end
            end
         end
         lkvc_pkg::OP_REMOVE: begin
            if (hit_slot >= 0)
               retire_entry(hit_slot);
         end
         default: begin
         end
      endcase

      result.found      = (hit_slot >= 0);
      result.occupancy  = occupied[lkvc_pkg::OCC_BITS-1:0];
      result.hit_total  = hit_count;
      result.miss_total = miss_count;
      return result;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("response %0d: %s got %h want %h", response_index, what, got, want);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_responses.push_back(apply_request(req_data));
            send_gap = next_wait(sender_calm);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               req_data  <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         accept_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_responses.size() == 0) begin
               report_mismatch("response with none expected", '0, '0);
            end else begin
               wanted = predicted_responses.pop_front();
               if (rsp_data.found !== wanted.found)
                  report_mismatch("found", 32'(rsp_data.found), 32'(wanted.found));
               if (rsp_data.read_value !== wanted.read_value)
                  report_mismatch("read_value", rsp_data.read_value, wanted.read_value);
               if (rsp_data.occupancy !== wanted.occupancy)
                  report_mismatch("occupancy", 32'(rsp_data.occupancy),
                                  32'(wanted.occupancy));
               if (rsp_data.hit_total !== wanted.hit_total)
                  report_mismatch("hit_total", rsp_data.hit_total, wanted.hit_total);
               if (rsp_data.miss_total !== wanted.miss_total)
                  report_mismatch("miss_total", rsp_data.miss_total, wanted.miss_total);
            end
            response_index++;
            accept_hold = next_wait(receiver_calm);
         end
         if (accept_hold > 0) begin
            accept_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic enqueue_request(lkvc_pkg::op_type op,
                                  logic [lkvc_pkg::KEY_BITS-1:0] key,
                                  logic [lkvc_pkg::VALUE_BITS-1:0] value);
      lkvc_pkg::req_type item;
      item.op          = op;
      item.lookup_key  = key;
      item.write_value = value;
      pending_requests.push_back(item);
   endtask

   // block is idle once every request has gone in and every response come out
   task automatic wait_until_idle();
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || predicted_responses.size() != 0);
   endtask

   task automatic write_capacity(int cap);
      wait_until_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap[lkvc_pkg::LIMIT_BITS-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      capacity_setting = cap[lkvc_pkg::LIMIT_BITS-1:0];
      @(negedge clock);
   endtask

   // stimulus
   initial begin : stimulus
      logic [lkvc_pkg::KEY_BITS-1:0] key_pool [$];
      logic [lkvc_pkg::KEY_BITS-1:0] key;
      lkvc_pkg::op_type              op;
      int                            phase;
      int                            pool_size;
      int                            usable;
      int                            k;
      int                            pick;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: edge keys and values, misses, update, remove at reset capacity
      enqueue_request(lkvc_pkg::OP_GET,      32'h0000_0000, 32'h0000_0000);
      enqueue_request(lkvc_pkg::OP_CONTAINS, 32'hFFFF_FFFF, 32'h0000_0000);
      enqueue_request(lkvc_pkg::OP_REMOVE,   32'h1234_5678, 32'hFFFF_FFFF);
      enqueue_request(lkvc_pkg::OP_PUT,      32'h0000_0000, 32'hFFFF_FFFF);
      enqueue_request(lkvc_pkg::OP_PUT,      32'hFFFF_FFFF, 32'h0000_0000);
      enqueue_request(lkvc_pkg::OP_GET,      32'h0000_0000, 32'h0000_0000);
      enqueue_request(lkvc_pkg::OP_CONTAINS, 32'hFFFF_FFFF, 32'h0000_0000);
      enqueue_request(lkvc_pkg::OP_PUT,      32'h0000_0000, 32'h5A5A_5A5A);
      enqueue_request(lkvc_pkg::OP_GET,      32'h0000_0000, 32'hDEAD_BEEF);
      enqueue_request(lkvc_pkg::OP_REMOVE,   32'hFFFF_FFFF, 32'h0000_0000);
      enqueue_request(lkvc_pkg::OP_GET,      32'hFFFF_FFFF, 32'h0000_0000);
      enqueue_request(lkvc_pkg::OP_CONTAINS, 32'h0000_0000, 32'hA5A5_A5A5);

      // capacity of one: every new key evicts the previous one
      write_capacity(1);
      enqueue_request(lkvc_pkg::OP_PUT, 32'h0000_00A0, 32'h1111_1111);
      enqueue_request(lkvc_pkg::OP_PUT, 32'h0000_00B0, 32'h2222_2222);
      enqueue_request(lkvc_pkg::OP_GET, 32'h0000_00A0, 32'h0000_0000);
      enqueue_request(lkvc_pkg::OP_GET, 32'h0000_00B0, 32'h0000_0000);

      // zero capacity behaves as one
      write_capacity(0);
      enqueue_request(lkvc_pkg::OP_PUT,      32'h0000_00C0, 32'h3333_3333);
      enqueue_request(lkvc_pkg::OP_CONTAINS, 32'h0000_00B0, 32'h0000_0000);

      // a get refreshes recency so the next oldest key is evicted
      write_capacity(3);
      enqueue_request(lkvc_pkg::OP_PUT,      32'h8000_0001, 32'h0000_0001);
      enqueue_request(lkvc_pkg::OP_PUT,      32'h8000_0002, 32'h0000_0002);
      enqueue_request(lkvc_pkg::OP_PUT,      32'h8000_0003, 32'h0000_0003);
      enqueue_request(lkvc_pkg::OP_GET,      32'h8000_0001, 32'h0000_0000);
      enqueue_request(lkvc_pkg::OP_PUT,      32'h8000_0004, 32'h0000_0004);
      enqueue_request(lkvc_pkg::OP_CONTAINS, 32'h8000_0002, 32'h0000_0000);
      enqueue_request(lkvc_pkg::OP_CONTAINS, 32'h8000_0001, 32'h0000_0000);

      // random phases over a range of capacity settings
      for (phase = 0; phase < 11; phase++) begin
         write_capacity(capacity_plan[phase]);
         usable = (capacity_plan[phase] == 0) ? 1 :
                  (capacity_plan[phase] > CACHE_ENTRIES) ? CACHE_ENTRIES :
                  capacity_plan[phase];
         pool_size = usable + $urandom_range(1, 6);
         key_pool.delete();
         for (k = 0; k < pool_size; k++) begin
            key = $urandom;
            if ($urandom_range(0, 7) == 0)
               key = $urandom_range(0, 1) ? '1 : '0;
            key_pool.push_back(key);
         end

         // fill with the working set first, then mix operations over it
         for (k = 0; k < pool_size; k++)
            enqueue_request(lkvc_pkg::OP_PUT, key_pool[k], $urandom);
         for (k = 0; k < 125; k++) begin
            pick = $urandom_range(0, 19);
            op = (pick < 7) ? lkvc_pkg::OP_PUT : (pick < 14) ? lkvc_pkg::OP_GET :
                 (pick < 16) ? lkvc_pkg::OP_REMOVE : lkvc_pkg::OP_CONTAINS;
            pick = $urandom_range(0, 19);
            if (pick == 0)
               key = $urandom;
            else if (pick == 1)
               key = $urandom_range(0, 1) ? '1 : '0;
            else
               key = key_pool[$urandom_range(0, pool_size - 1)];
            enqueue_request(op, key, $urandom);
         end
      end

      // drain and let the pipeline settle
      wait_until_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
